// ===== design/nfa_pkg.sv =====
// Shared types and constants for the NFA regex character matcher.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package nfa_pkg;

  localparam int MAX_STATES = 64;
  localparam int STATE_IW   = $clog2(MAX_STATES);
  localparam int CNT_W      = $clog2(MAX_STATES + 1);
  localparam int FINAL_W    = 6;
  localparam int IDX_W      = 6;
  localparam int CMP_W      = 7;

  typedef enum logic [1:0] {
    CMD_LOAD_SYM = 2'd0,
    CMD_LOAD_EPS = 2'd1,
    CMD_RESTART  = 2'd2,
    CMD_TEXT     = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;
  localparam logic [1:0] KIND_OPER  = 2'd3;

  localparam logic CFG_FINAL  = 1'b0;
  localparam logic CFG_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      val;
    logic            inv;
    logic [2:0][7:0] lo;
    logic [2:0][7:0] hi;
  } sym_t;

endpackage

// ===== design/nfa_sym_match.sv =====
// Symbol compare unit: tests one stored symbol against one text byte.
// Depends on nfa_pkg for the symbol layout and kind codes.
`timescale 1ns / 1ps

module nfa_sym_match (
  input  nfa_pkg::sym_t sym,
  input  logic [7:0]    byte_in,
  output logic          match
);
  import nfa_pkg::*;

  localparam logic [3:0] CLS_MISC  = 4'd0;
  localparam logic [3:0] CLS_LOWER = 4'd1;
  localparam logic [3:0] CLS_UPPER = 4'd2;
  localparam logic [3:0] CLS_PRINT = 4'd3;
  localparam logic [3:0] CLS_DIGIT = 4'd4;
  localparam logic [3:0] CLS_HEX   = 4'd5;
  localparam logic [3:0] CLS_ALNUM = 4'd6;

  function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  logic dig, up, low, cls_hit, rng_hit;

  always_comb begin
    dig = in_rng(byte_in, 8'd48, 8'd57);
    up  = in_rng(byte_in, 8'd65, 8'd90);
    low = in_rng(byte_in, 8'd97, 8'd122);
    cls_hit = 1'b0;
    if (sym.val[7:4] == 4'd0) begin
      unique case (sym.val[3:0])
        CLS_MISC:  cls_hit = in_rng(byte_in, 8'd32, 8'd47) || in_rng(byte_in, 8'd58, 8'd64) ||
                             in_rng(byte_in, 8'd91, 8'd96) || in_rng(byte_in, 8'd123, 8'd126);
        CLS_LOWER: cls_hit = low;
        CLS_UPPER: cls_hit = up;
        CLS_PRINT: cls_hit = in_rng(byte_in, 8'd32, 8'd126);
        CLS_DIGIT: cls_hit = dig;
        CLS_HEX:   cls_hit = dig || in_rng(byte_in, 8'd65, 8'd70) ||
                             in_rng(byte_in, 8'd97, 8'd102);
        CLS_ALNUM: cls_hit = dig || up || low;
        default:   cls_hit = 1'b0;
      endcase
    end
    rng_hit = in_rng(byte_in, sym.lo[0], sym.hi[0]) || in_rng(byte_in, sym.lo[1], sym.hi[1]) ||
              in_rng(byte_in, sym.lo[2], sym.hi[2]);
    unique case (sym.kind)
      KIND_LIT:   match = (byte_in == sym.val);
      KIND_CLASS: match = cls_hit;
      KIND_RANGE: match = rng_hit ^ sym.inv;
      KIND_OPER:  match = 1'b0;
      default:    match = 1'b0;
    endcase
  end

endmodule

// ===== design/nfa_store.sv =====
// Automaton store: symbol table and epsilon-edge rows, one write port and
// one registered read port with separate addresses. Depends on nfa_pkg.
`timescale 1ns / 1ps

module nfa_store (
  input  logic                              clk,
  input  logic                              we_sym,
  input  logic                              we_eps,
  input  logic [nfa_pkg::STATE_IW-1:0]      waddr,
  input  nfa_pkg::sym_t                     wsym,
  input  logic [nfa_pkg::MAX_STATES-1:0]    wrow,
  input  logic                              rd_en,
  input  logic [nfa_pkg::STATE_IW-1:0]      raddr,
  output nfa_pkg::sym_t                     sym_q,
  output logic [nfa_pkg::MAX_STATES-1:0]    row_q
);
  import nfa_pkg::*;

  sym_t                  sym_mem [MAX_STATES];
  logic [MAX_STATES-1:0] eps_mem [MAX_STATES];

  always_ff @(posedge clk) begin
    if (we_sym) sym_mem[waddr] <= wsym;
    if (we_eps) eps_mem[waddr] <= wrow;
    if (rd_en) begin
      sym_q <= sym_mem[raddr];
      row_q <= eps_mem[raddr];
    end
  end

endmodule

// ===== design/nfa_regex_char_matcher.sv =====
// NFA regex character matcher: loads, restarts and text bytes; one result per request.
// Loads go straight to the response; a restart runs closure sweeps, a text byte one move sweep
// then closure sweeps, repeated until a sweep adds no state. One request in flight.
// Each sweep reads through the single read port of the store: one state per cycle.
// Reset (rst_n low, synchronous): active set, byte history and flags clear, final_state=1.
// Depends on nfa_pkg, nfa_store and nfa_sym_match.
`timescale 1ns / 1ps

module nfa_regex_char_matcher (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_state_index,
  input  logic [1:0]  in_sym_kind,
  input  logic [7:0]  in_byte_value,
  input  logic        in_range_invert,
  input  logic [7:0]  in_range_lo_a,
  input  logic [7:0]  in_range_hi_a,
  input  logic [7:0]  in_range_lo_b,
  input  logic [7:0]  in_range_hi_b,
  input  logic [7:0]  in_range_lo_c,
  input  logic [7:0]  in_range_hi_c,
  input  logic [63:0] in_edge_row,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_text_rejected,
  output logic        out_any_active,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);
  import nfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_CLOS,
    S_RESP
  } state_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic [STATE_IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [MAX_STATES-1:0] set_r, set_nxt;
  logic [MAX_STATES-1:0] active_r, active_nxt;
  logic                  changed_r, changed_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic [7:0]            prior_r, prior_nxt;
  logic                  seen_r, seen_nxt;
  logic                  reject_r, reject_nxt;
  logic [FINAL_W-1:0]    final_r, final_nxt;
  logic                  reject_en_r, reject_en_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  acc_r, acc_nxt;
  logic                  rej_r, rej_nxt;
  logic                  any_r, any_nxt;

  // store and compare unit hookup
  logic                  we_sym, we_eps, rd_en, match;
  logic [STATE_IW-1:0]   waddr;
  sym_t                  wsym, sym_q;
  logic [MAX_STATES-1:0] row_q, grow;
  logic                  in_fire, idx_ok, is_meta, sweep_end, grew;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign idx_ok   = CMP_W'(in_state_index) < CMP_W'(MAX_STATES);
  assign waddr    = in_state_index[STATE_IW-1:0];
  assign we_sym   = in_fire && (cmd_t'(in_cmd) == CMD_LOAD_SYM) && idx_ok;
  assign we_eps   = in_fire && (cmd_t'(in_cmd) == CMD_LOAD_EPS) && idx_ok;

  always_comb begin
    wsym.kind  = in_sym_kind;
    wsym.val   = in_byte_value;
    wsym.inv   = in_range_invert;
    wsym.lo[0] = in_range_lo_a;
    wsym.hi[0] = in_range_hi_a;
    wsym.lo[1] = in_range_lo_b;
    wsym.hi[1] = in_range_hi_b;
    wsym.lo[2] = in_range_lo_c;
    wsym.hi[2] = in_range_hi_c;
  end

  assign is_meta = (in_byte_value == CH_LPAREN) || (in_byte_value == CH_RPAREN) ||
                   (in_byte_value == CH_STAR)   || (in_byte_value == CH_QMARK)  ||
                   (in_byte_value == CH_CARET)  || (in_byte_value == CH_PIPE);

  nfa_store u_store (
    .clk    (clk),
    .we_sym (we_sym),
    .we_eps (we_eps),
    .waddr  (waddr),
    .wsym   (wsym),
    .wrow   (in_edge_row[MAX_STATES-1:0]),
    .rd_en  (rd_en),
    .raddr  (cnt_r[STATE_IW-1:0]),
    .sym_q  (sym_q),
    .row_q  (row_q)
  );

  // one symbol per cycle against the held text byte
  nfa_sym_match u_match (
    .sym     (sym_q),
    .byte_in (byte_r),
    .match   (match)
  );

  assign sweep_end = (cnt_r == CNT_W'(MAX_STATES));
  assign grow      = row_q & ~set_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_valid_nxt  = 1'b0;
    rd_idx_nxt    = cnt_r[STATE_IW-1:0];
    set_nxt       = set_r;
    active_nxt    = active_r;
    changed_nxt   = changed_r;
    byte_nxt      = byte_r;
    prior_nxt     = prior_r;
    seen_nxt      = seen_r;
    reject_nxt    = reject_r;
    final_nxt     = final_r;
    reject_en_nxt = reject_en_r;
    out_valid_nxt = out_valid_r && out_stall;
    acc_nxt       = acc_r;
    rej_nxt       = rej_r;
    any_nxt       = any_r;
    rd_en         = 1'b0;
    grew          = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FINAL:  final_nxt     = cfg_wdata[FINAL_W-1:0];
        CFG_REJECT: reject_en_nxt = cfg_wdata[0];
        default:    ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt     = '0;
          changed_nxt = 1'b0;
          unique case (cmd_t'(in_cmd)) inside
            CMD_LOAD_SYM, CMD_LOAD_EPS: state_nxt = S_RESP;
            CMD_RESTART: begin
              // closure of the start state
              set_nxt    = MAX_STATES'(1);
              prior_nxt  = '0;
              seen_nxt   = 1'b0;
              reject_nxt = 1'b0;
              state_nxt  = S_CLOS;
            end
            CMD_TEXT: begin
              if (reject_en_r && seen_r && (prior_r != CH_BSLASH) && is_meta)
                reject_nxt = 1'b1;
              prior_nxt = in_byte_value;
              seen_nxt  = 1'b1;
              byte_nxt  = in_byte_value;
              set_nxt   = '0;
              state_nxt = S_MOVE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_MOVE: begin
        // issue one state read per cycle; consume it the cycle after
        rd_en        = !sweep_end;
        rd_valid_nxt = rd_en;
        if (!sweep_end) cnt_nxt = cnt_r + CNT_W'(1);
        if (rd_valid_r && active_r[rd_idx_r] && match &&
            (FINAL_W'(rd_idx_r) != final_r) &&
            (rd_idx_r != STATE_IW'(MAX_STATES - 1)))
          set_nxt[rd_idx_r + STATE_IW'(1)] = 1'b1;
        if (sweep_end) begin
          cnt_nxt     = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_CLOS;
        end
      end

      S_CLOS: begin
        // sweep epsilon rows in place; repeat while a sweep adds states
        rd_en        = !sweep_end;
        rd_valid_nxt = rd_en;
        if (!sweep_end) cnt_nxt = cnt_r + CNT_W'(1);
        if (rd_valid_r && set_r[rd_idx_r]) begin
          set_nxt = set_r | row_q;
          grew    = (grow != '0);
        end
        if (grew) changed_nxt = 1'b1;
        if (sweep_end) begin
          cnt_nxt     = '0;
          changed_nxt = 1'b0;
          if (!(changed_r || grew)) begin
            active_nxt = set_nxt;
            state_nxt  = S_RESP;
          end
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          acc_nxt = (CMP_W'(final_r) < CMP_W'(MAX_STATES)) &&
                    active_r[final_r[STATE_IW-1:0]];
          rej_nxt   = reject_r;
          any_nxt   = (active_r != '0);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      active_r    <= '0;
      changed_r   <= 1'b0;
      prior_r     <= '0;
      seen_r      <= 1'b0;
      reject_r    <= 1'b0;
      final_r     <= FINAL_W'(1);
      reject_en_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_valid_r  <= rd_valid_nxt;
      active_r    <= active_nxt;
      changed_r   <= changed_nxt;
      prior_r     <= prior_nxt;
      seen_r      <= seen_nxt;
      reject_r    <= reject_nxt;
      final_r     <= final_nxt;
      reject_en_r <= reject_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    set_r    <= set_nxt;
    byte_r   <= byte_nxt;
    acc_r    <= acc_nxt;
    rej_r    <= rej_nxt;
    any_r    <= any_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_text_rejected = rej_r;
  assign out_any_active    = any_r;

endmodule
